// ===== sv/b58_pkg.sv =====
// Shared sizes, RAM request type and the digit alphabet for the base-58 encoder.
// No dependencies; used by every other file of the block.
package b58_pkg;

   localparam int MAX_BYTES  = 32;
   localparam int DIGITS     = 45;
   localparam int RESULT_CAP = 64;

   localparam int DIGIT_AW = $clog2(DIGITS);
   localparam int STEP_W   = $clog2(DIGITS + 1);
   localparam int CNT_W    = $clog2(MAX_BYTES + 1);
   localparam int RES_W    = $clog2(RESULT_CAP + 1);
   localparam int SUM_W    = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 1;
   localparam int TOT_W    = (SUM_W > RES_W) ? SUM_W : RES_W;

   // floor(x / 58) = (x * RECIP_M) >> RECIP_SH, exact for x < 2048
   localparam int RECIP_M  = 565;
   localparam int RECIP_SH = 15;

   typedef struct packed {
      logic                rd_en;
      logic [DIGIT_AW-1:0] rd_addr;
      logic                wr_en;
      logic [DIGIT_AW-1:0] wr_addr;
      logic [5:0]          wr_data;
      logic                clear;
   } ram_req_type;

   // base-58 digit to ASCII, alphabet without 0, O, I and l
   function automatic logic [6:0] b58_char(input logic [5:0] d);
      logic [6:0] c;
      if (d < 6'd9)       c = 7'(d) + 7'd49;
      else if (d < 6'd17) c = 7'(d) + 7'd56;
      else if (d < 6'd22) c = 7'(d) + 7'd57;
      else if (d < 6'd33) c = 7'(d) + 7'd58;
      else if (d < 6'd44) c = 7'(d) + 7'd64;
      else                c = 7'(d) + 7'd65;
      return c;
   endfunction

endpackage

// ===== sv/b58_digit_ram.sv =====
// Digit store: synchronous RAM with registered read data and per-entry valid bits.
// Depends on b58_pkg; entries not written since the last clear read as zero.
module b58_digit_ram (
   input  logic                 clock,
   input  logic                 reset,
   input  b58_pkg::ram_req_type ram_req,
   output logic [5:0]           rd_data
);

   logic [5:0]              mem [b58_pkg::DIGITS];
   logic [b58_pkg::DIGITS-1:0] vld_ff;
   logic [5:0]              rd_word_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_word_ff <= mem[ram_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ram_req.clear) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            vld_ff[ram_req.wr_addr] <= 1'b1;
         end
         if (ram_req.rd_en) begin
            rd_vld_ff <= vld_ff[ram_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : 6'd0;

endmodule

// ===== sv/b58_digit_mac.sv =====
// One digit step: digit * 256 + carry split into a new base-58 digit and carry.
// Depends on b58_pkg for the reciprocal constants.
module b58_digit_mac (
   input  logic [5:0] digit_in,
   input  logic [7:0] carry_in,
   output logic [5:0] digit_out,
   output logic [7:0] carry_out
);

   // d*256 + c = 58*(4d) + (24d + c); 24d + c stays below 2048
   logic [10:0] part;
   logic [20:0] prod;
   logic [4:0]  quo;
   logic [10:0] rem;

   assign part = (11'(digit_in) << 4) + (11'(digit_in) << 3) + 11'(carry_in);
   assign prod = 21'(part) * 21'(b58_pkg::RECIP_M);
   assign quo  = prod[b58_pkg::RECIP_SH +: 5];
   // quo * 58 = quo*64 - quo*4 - quo*2
   assign rem  = part - ((11'(quo) << 6) - (11'(quo) << 2) - (11'(quo) << 1));

   assign digit_out = rem[5:0];
   assign carry_out = 8'({digit_in, 2'b00}) + 8'(quo);

endmodule

// ===== sv/base58_encoder.sv =====
// Base-58 encoder top level: request FSM, digit-store sweep and character emission.
// Depends on b58_pkg, b58_digit_ram and b58_digit_mac.
//
// Usage:
//   req_ channel takes one message byte per item, most significant first;
//   req_last_byte marks the end of the message. Up to MAX_BYTES bytes are
//   absorbed, later bytes are dropped and flag rsp_overflow on every result.
//   rsp_ channel returns the encoding one ASCII character per item: one '1'
//   per leading zero byte, then the base-58 digits, most significant first;
//   rsp_last_char marks the final character (at most RESULT_CAP of them).
//   An empty or all-zero-valued message with no zero bytes gives a single '1'.
// Operation:
//   Each absorbed byte sweeps the digit store: the carry walks it one entry
//   per cycle through the single read/write RAM. A dropped byte is taken in
//   S_IDLE with no sweep. After the last byte comes S_SETUP, then per
//   character S_NEXT, S_DATA for digit characters (they need a RAM read) and
//   S_WAIT, which holds until rsp_ready.
// Reset and stall:
//   Synchronous reset clears the FSM state, the byte and digit counts, the
//   flags and the store's valid bits, so the block is ready in the first
//   cycle after reset. While a character waits for rsp_ready nothing else
//   moves; no new byte is taken until the whole encoding has been delivered.
module base58_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_char_code,
   output logic       rsp_last_char,
   output logic       rsp_overflow
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ABSORB = 3'd1;
   localparam logic [2:0] S_SETUP  = 3'd2;
   localparam logic [2:0] S_NEXT   = 3'd3;
   localparam logic [2:0] S_DATA   = 3'd4;
   localparam logic [2:0] S_WAIT   = 3'd5;

   localparam int DAW = b58_pkg::DIGIT_AW;
   localparam int SW  = b58_pkg::STEP_W;
   localparam int CW  = b58_pkg::CNT_W;
   localparam int RW  = b58_pkg::RES_W;
   localparam int TW  = b58_pkg::TOT_W;

   logic [2:0]     state_ff,   state_in;
   logic [SW-1:0]  step_ff,    step_in;
   logic [7:0]     carry_ff,   carry_in;
   logic [SW-1:0]  top_ff,     top_in;
   logic [SW-1:0]  used_ff,    used_in;
   logic [CW-1:0]  lz_ff,      lz_in;
   logic           seen_ff,    seen_in;
   logic [CW-1:0]  count_ff,   count_in;
   logic           ovf_ff,     ovf_in;
   logic           last_ff,    last_in;
   logic [RW-1:0]  k_ff,       k_in;
   logic [RW-1:0]  total_ff,   total_in;
   logic [DAW-1:0] dig_idx_ff, dig_idx_in;
   logic [6:0]     char_ff,    char_in;
   logic           lastc_ff,   lastc_in;

   b58_pkg::ram_req_type ram_req;
   logic [5:0]     rd_data;
   logic [5:0]     mac_digit;
   logic [7:0]     mac_carry;

   logic           req_accept;
   logic [SW-1:0]  step_m1;
   logic [SW-1:0]  top_new;
   logic [SW-1:0]  used_m1;
   logic [TW-1:0]  sum_ext;
   logic [TW-1:0]  total_ext;
   logic [RW-1:0]  k_p1;

   b58_digit_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   b58_digit_mac u_mac (
      .digit_in  (rd_data),
      .carry_in  (carry_ff),
      .digit_out (mac_digit),
      .carry_out (mac_carry)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;

   assign step_m1 = step_ff - SW'(1);
   assign top_new = (mac_digit != 6'd0) ? step_ff : top_ff;
   assign used_m1 = used_ff - SW'(1);
   assign sum_ext = TW'(lz_ff) + TW'(used_ff);
   assign k_p1    = k_ff + RW'(1);

   always_comb begin
      if (sum_ext == TW'(0)) begin
         total_ext = TW'(1);
      end else if (sum_ext > TW'(b58_pkg::RESULT_CAP)) begin
         total_ext = TW'(b58_pkg::RESULT_CAP);
      end else begin
         total_ext = sum_ext;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      carry_in   = carry_ff;
      top_in     = top_ff;
      used_in    = used_ff;
      lz_in      = lz_ff;
      seen_in    = seen_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      last_in    = last_ff;
      k_in       = k_ff;
      total_in   = total_ff;
      dig_idx_in = dig_idx_ff;
      char_in    = char_ff;
      lastc_in   = lastc_ff;

      ram_req         = '0;
      ram_req.wr_data = mac_digit;
      ram_req.wr_addr = step_m1[DAW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (count_ff < CW'(b58_pkg::MAX_BYTES)) begin
                  count_in = count_ff + CW'(1);
                  if (!seen_ff && (req_data_byte == 8'd0)) begin
                     lz_in = lz_ff + CW'(1);
                  end else begin
                     seen_in = 1'b1;
                  end
                  // fetch entry 0 now so the sweep starts next cycle
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = DAW'(0);
                  carry_in = req_data_byte;
                  top_in   = '0;
                  step_in  = SW'(1);
                  last_in  = req_last_byte;
                  state_in = S_ABSORB;
               end else begin
                  ovf_in = 1'b1;
                  if (req_last_byte) begin
                     state_in = S_SETUP;
                  end
               end
            end
         end

         S_ABSORB: begin
            // entry step-1 is in rd_data; write back the new digit
            ram_req.wr_en = 1'b1;
            carry_in      = mac_carry;
            top_in        = top_new;
            if (step_ff < SW'(b58_pkg::DIGITS)) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = step_ff[DAW-1:0];
               step_in         = step_ff + SW'(1);
            end else begin
               // carry out of the top digit is dropped
               used_in  = top_new;
               state_in = last_ff ? S_SETUP : S_IDLE;
            end
         end

         S_SETUP: begin
            total_in   = RW'(total_ext);
            k_in       = '0;
            dig_idx_in = used_m1[DAW-1:0];
            state_in   = S_NEXT;
         end

         S_NEXT: begin
            lastc_in = (k_p1 == total_ff);
            if ((TW'(k_ff) < TW'(lz_ff)) || (used_ff == SW'(0))) begin
               char_in  = b58_pkg::b58_char(6'd0);
               state_in = S_WAIT;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = dig_idx_ff;
               state_in        = S_DATA;
            end
         end

         S_DATA: begin
            char_in    = b58_pkg::b58_char(rd_data);
            dig_idx_in = dig_idx_ff - DAW'(1);
            state_in   = S_WAIT;
         end

         S_WAIT: begin
            if (rsp_ready) begin
               k_in = k_p1;
               if (lastc_ff) begin
                  // message done: back to the reset picture
                  ram_req.clear = 1'b1;
                  used_in  = '0;
                  lz_in    = '0;
                  seen_in  = 1'b0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         lz_ff    <= '0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         lz_ff    <= lz_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      carry_ff   <= carry_in;
      top_ff     <= top_in;
      last_ff    <= last_in;
      k_ff       <= k_in;
      total_ff   <= total_in;
      dig_idx_ff <= dig_idx_in;
      char_ff    <= char_in;
      lastc_ff   <= lastc_in;
   end

   assign rsp_valid     = (state_ff == S_WAIT);
   assign rsp_char_code = char_ff;
   assign rsp_last_char = lastc_ff;
   assign rsp_overflow  = ovf_ff;

endmodule

// ===== tb/base58_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the base-58 encoder: predicts each encoding from the accepted bytes
// and compares every returned character field by field. Depends on b58_pkg.
module base58_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [6:0] rsp_char_code,
   input  logic       rsp_last_char,
   input  logic       rsp_overflow,
   output int         mismatches,
   output int         outstanding
);

   typedef struct packed {
      logic [6:0] code;
      logic       last;
      logic       ovf;
   } enc_char_type;

   localparam logic [58*8-1:0] ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   logic [5:0]   digit_acc [b58_pkg::DIGITS];   // base-58 digits, entry 0 least significant
   int unsigned  sig_digits;
   int unsigned  zero_prefix;
   int unsigned  bytes_taken;
   bit           nonzero_seen;
   bit           bytes_dropped;
   enc_char_type expected_chars[$];
   enc_char_type want;
   int           fail_total = 0;

   function automatic logic [6:0] glyph(input logic [5:0] d);
      return 7'(ALPHABET[(57 - int'(d)) * 8 +: 8]);
   endfunction

   task automatic clear_message();
      for (int i = 0; i < b58_pkg::DIGITS; i++) digit_acc[i] = '0;
      sig_digits    = 0;
      zero_prefix   = 0;
      bytes_taken   = 0;
      nonzero_seen  = 0;
      bytes_dropped = 0;
   endtask

   task automatic predict_item(input logic [7:0] b, input logic lst);
      enc_char_type burst[$];
      int unsigned  carry;
      int unsigned  v;
      int unsigned  top;
      if (bytes_taken < b58_pkg::MAX_BYTES) begin
         bytes_taken++;
         if (!nonzero_seen && b == 8'd0) zero_prefix++;
         else nonzero_seen = 1;
         // value = value * 256 + byte, carry rippling up through every digit
         carry = b;
         top   = 0;
         for (int i = 0; i < b58_pkg::DIGITS; i++) begin
            v            = int'(digit_acc[i]) * 256 + carry;
            digit_acc[i] = 6'(v % 58);
            carry        = v / 58;
            if (digit_acc[i] != 6'd0) top = i + 1;
         end
         sig_digits = top;
      end else begin
         bytes_dropped = 1;
      end
      if (lst) begin
         for (int i = 0; i < zero_prefix && burst.size() < b58_pkg::RESULT_CAP; i++)
            burst.push_back('{code: glyph(6'd0), last: 1'b0, ovf: bytes_dropped});
         for (int i = sig_digits; i > 0 && burst.size() < b58_pkg::RESULT_CAP; i--)
            burst.push_back('{code: glyph(digit_acc[i-1]), last: 1'b0, ovf: bytes_dropped});
         // zero value and no zero bytes still yields one '1'
         if (burst.size() == 0)
            burst.push_back('{code: glyph(6'd0), last: 1'b1, ovf: bytes_dropped});
         else
            burst[burst.size()-1].last = 1'b1;
         foreach (burst[k]) expected_chars.push_back(burst[k]);
         clear_message();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         expected_chars.delete();
      end else begin
         if (req_valid && req_ready) predict_item(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("checker: unexpected char code %0d last %0d ovf %0d",
                           rsp_char_code, rsp_last_char, rsp_overflow);
            end else begin
               want = expected_chars.pop_front();
               if (want.code !== rsp_char_code || want.last !== rsp_last_char ||
                   want.ovf !== rsp_overflow) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("checker: expected code %0d last %0d ovf %0d, got %0d %0d %0d",
                              want.code, want.last, want.ovf,
                              rsp_char_code, rsp_last_char, rsp_overflow);
               end
            end
         end
      end
      mismatches  <= fail_total;
      outstanding <= expected_chars.size();
   end

endmodule

// ===== tb/tb_base58_encoder.sv =====
`timescale 1ns / 1ps
// Top of the base-58 encoder testbench: clock, reset, message stimulus and verdict.
// Depends on base58_encoder (with b58_pkg) and base58_checker.
module tb_base58_encoder;

   typedef enum int {MSG_RANDOM, MSG_ONES, MSG_ZEROS, MSG_LEADZ} msg_kind_type;

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [6:0] rsp_char_code;
   logic       rsp_last_char;
   logic       rsp_overflow;

   logic steady = 1'b0;   // high: neither side inserts idle cycles
   int   mismatches;
   int   outstanding;
   int   items_sent = 0;

   base58_encoder DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .rsp_overflow  (rsp_overflow)
   );

   base58_checker CHECK (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .rsp_overflow  (rsp_overflow),
      .mismatches    (mismatches),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stalls at random about 6 percent of the time, never during the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 6);
   end

   // One byte item: optional idle gap, then valid held with a fixed payload
   // until the block takes it. Valid is left high for a following item.
   task automatic send_byte(input logic [7:0] b, input logic lst);
      if (!steady) begin
         while ($urandom_range(0, 99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // A whole message of len bytes; the last byte carries the end mark.
   // Beyond 32 bytes the tail is dropped by the block, but its end mark still closes the message.
   task automatic send_message(input int len, input msg_kind_type kind);
      logic [7:0] b;
      int         nz;
      nz = $urandom_range(1, len);
      for (int i = 0; i < len; i++) begin
         case (kind)
            MSG_ONES:  b = 8'hFF;
            MSG_ZEROS: b = 8'h00;
            MSG_LEADZ: b = (i < nz) ? 8'h00 : 8'($urandom);
            default:   b = 8'($urandom);
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int           m;
      int           r;
      int           len;
      msg_kind_type kind;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: single zero byte, extreme byte values, exact powers of 58,
      // runs of leading zeros, an all-zero message and a high-valued run.
      send_message(1, MSG_ZEROS);
      send_message(1, MSG_ONES);
      send_byte(8'h01, 1'b1);
      send_byte(8'd58, 1'b1);
      send_message(3, MSG_ZEROS);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'd57, 1'b1);
      send_message(5, MSG_ONES);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);

      // Random messages; a few take the full 32 bytes or overflow the byte limit.
      m = 0;
      while (items_sent < 170) begin
         steady <= (m >= 10 && m < 22);
         if (m == 3) begin
            send_message(32, MSG_ONES);               // largest value
         end else if (m == 8) begin
            send_message($urandom_range(33, 36), MSG_RANDOM);  // overflow
         end else if (m == 14) begin
            send_message(33, MSG_ZEROS);              // overflow, all zero
         end else if (m == 18) begin
            send_message(34, MSG_LEADZ);
         end else begin
            r = $urandom_range(0, 9);
            case (r)
               5:       kind = MSG_ONES;
               6:       kind = MSG_ZEROS;
               7, 8, 9: kind = MSG_LEADZ;
               default: kind = MSG_RANDOM;
            endcase
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 31)
                                               : $urandom_range(1, 8);
            send_message(len, kind);
         end
         m++;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (100) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
